// ===== rtl/core/wsf_pkg.sv =====
// Package for the Wigner-Seitz fold block: widths, neighbour table, types.
// No dependencies.
package wsf_pkg;
  localparam int NEIGHBOURS = 13;
  localparam int MAX_PASSES_DEF = 10;
  localparam int MAX_STEPS_DEF = 256;
  localparam int LAT_BITS = 21;
  localparam int NB_BITS = 23;
  localparam int POS_BITS = 32;
  localparam int VW = 48;
  localparam int DW = 64;
  localparam int NORM_BITS = 48;
  localparam int NIDX_BITS = 4;

  typedef enum logic [1:0] {
    REG_A = 2'd0,
    REG_B = 2'd1,
    REG_C = 2'd2
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DOT,
    ST_CMP,
    ST_STEP,
    ST_DONE
  } back_state_t;

  typedef logic signed [1:0] coef_t;

  function automatic coef_t coef(input logic [NIDX_BITS-1:0] n, input logic [1:0] j);
    logic [5:0] row;
    coef_t c;
    begin
      case (n)
        4'd0:    row = 6'b01_00_00;
        4'd1:    row = 6'b00_01_00;
        4'd2:    row = 6'b00_00_01;
        4'd3:    row = 6'b01_01_00;
        4'd4:    row = 6'b01_11_00;
        4'd5:    row = 6'b00_01_01;
        4'd6:    row = 6'b00_01_11;
        4'd7:    row = 6'b01_00_01;
        4'd8:    row = 6'b11_00_01;
        4'd9:    row = 6'b01_01_01;
        4'd10:   row = 6'b01_11_11;
        4'd11:   row = 6'b01_01_11;
        4'd12:   row = 6'b01_11_01;
        default: row = 6'b00_00_00;
      endcase
      case (j)
        2'd0:    c = row[5:4];
        2'd1:    c = row[3:2];
        default: c = row[1:0];
      endcase
      return c;
    end
  endfunction

  typedef struct packed {
    logic signed [POS_BITS-1:0] x;
    logic signed [POS_BITS-1:0] y;
    logic signed [POS_BITS-1:0] z;
  } pos_t;
endpackage

// ===== rtl/core/wsf_if.sv =====
// Valid/ready channel interfaces for the fold block.
// Depends on wsf_pkg.
interface wsf_in_if import wsf_pkg::*; ();
  logic valid;
  logic ready;
  logic signed [POS_BITS-1:0] vec_x;
  logic signed [POS_BITS-1:0] vec_y;
  logic signed [POS_BITS-1:0] vec_z;
  modport source (output valid, vec_x, vec_y, vec_z, input ready);
  modport sink (input valid, vec_x, vec_y, vec_z, output ready);
endinterface

interface wsf_out_if import wsf_pkg::*; ();
  logic valid;
  logic ready;
  logic signed [POS_BITS-1:0] folded_x;
  logic signed [POS_BITS-1:0] folded_y;
  logic signed [POS_BITS-1:0] folded_z;
  logic was_inside;
  logic converged;
  modport source (output valid, folded_x, folded_y, folded_z, was_inside, converged,
                  input ready);
  modport sink (input valid, folded_x, folded_y, folded_z, was_inside, converged,
                output ready);
endinterface

// ===== rtl/core/wsf_front.sv =====
// Front end: accepts positions into a two-entry queue.
// Depends on wsf_pkg and wsf_if.
module wsf_front import wsf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  wsf_in_if.sink      in_ch,
  output logic        q_valid,
  output pos_t        q_data,
  input  logic        q_pop
);
  pos_t       mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;

  assign in_ch.ready = (count != 2'd2);
  assign push = in_ch.valid && in_ch.ready;
  assign q_valid = (count != 2'd0);
  assign q_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= '{x: in_ch.vec_x, y: in_ch.vec_y, z: in_ch.vec_z};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (q_pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, q_pop};
    end
  end
endmodule

// ===== rtl/core/wsf_back.sv =====
// Back end: neighbour tables, fold sequencer and output register.
// Depends on wsf_pkg and wsf_if.
module wsf_back import wsf_pkg::*; #(
  parameter int MAX_PASSES = MAX_PASSES_DEF,
  parameter int MAX_STEPS = MAX_STEPS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [62:0]       lat_a,
  input  logic [62:0]       lat_b,
  input  logic [62:0]       lat_c,
  input  logic              q_valid,
  input  pos_t              q_data,
  output logic              q_pop,
  wsf_out_if.source         out_ch
);
  localparam int PW = $clog2(MAX_PASSES + 1);
  localparam int SW = $clog2(MAX_STEPS + 1);

  logic signed [NB_BITS-1:0]   nb [NEIGHBOURS][3];
  logic signed [NORM_BITS-1:0] norm [NEIGHBOURS];

  // Neighbour translations follow the registers directly.
  always_comb begin
    logic signed [LAT_BITS-1:0] l [3][3];
    logic signed [NB_BITS-1:0] s;
    for (int k = 0; k < 3; k++) begin
      l[0][k] = lat_a[LAT_BITS*k +: LAT_BITS];
      l[1][k] = lat_b[LAT_BITS*k +: LAT_BITS];
      l[2][k] = lat_c[LAT_BITS*k +: LAT_BITS];
    end
    for (int i = 0; i < NEIGHBOURS; i++) begin
      for (int k = 0; k < 3; k++) begin
        s = '0;
        for (int j = 0; j < 3; j++) begin
          case (coef(NIDX_BITS'(i), 2'(j)))
            2'sd1:   s = s + NB_BITS'(l[j][k]);
            -2'sd1:  s = s - NB_BITS'(l[j][k]);
            default: s = s;
          endcase
        end
        nb[i][k] = s;
      end
    end
  end

  // Norms are registered; each is three 23x23 products summed.
  always_ff @(posedge clk) begin
    for (int i = 0; i < NEIGHBOURS; i++) begin
      norm[i] <= NORM_BITS'(nb[i][0]) * NORM_BITS'(nb[i][0])
               + NORM_BITS'(nb[i][1]) * NORM_BITS'(nb[i][1])
               + NORM_BITS'(nb[i][2]) * NORM_BITS'(nb[i][2]);
    end
  end

  back_state_t state, state_next;
  logic signed [VW-1:0] v [3];
  logic signed [DW-1:0] dot;
  logic [NIDX_BITS-1:0] idx;
  logic [PW-1:0] pass;
  logic [SW-1:0] steps;
  logic          in_cell, changed, running, stepping, capped;
  logic          pos;
  logic          obusy;

  logic signed [DW-1:0] dn;
  logic signed [DW-1:0] twod;
  logic                 over_p, over_n;
  assign twod = dot <<< 1;
  assign over_p = twod > DW'(norm[idx]);
  assign over_n = -twod > DW'(norm[idx]);

  always_comb begin
    dn = DW'(v[0]) * DW'(nb[idx][0]) + DW'(v[1]) * DW'(nb[idx][1])
       + DW'(v[2]) * DW'(nb[idx][2]);
  end

  function automatic logic signed [POS_BITS-1:0] sat(input logic signed [VW-1:0] x);
    if (x > VW'(32'sh7fffffff)) return 32'sh7fffffff;
    if (x < -VW'(33'sh080000000)) return 32'sh80000000;
    return x[POS_BITS-1:0];
  endfunction

  function automatic logic ov(input logic signed [VW-1:0] x);
    return (x > VW'(32'sh7fffffff)) || (x < -VW'(33'sh080000000));
  endfunction

  assign q_pop = (state == ST_IDLE) && q_valid;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (q_valid) state_next = ST_DOT;
      ST_DOT:  state_next = ST_CMP;
      ST_CMP:  begin
        if (!running) begin
          state_next = ST_DOT;
        end else if (stepping) begin
          if (pos ? over_p : over_n) begin
            state_next = (steps == SW'(MAX_STEPS)) ? ST_DONE : ST_STEP;
          end else begin
            state_next = (pass + 1'b1 == PW'(MAX_PASSES)) ? ST_DONE : ST_DOT;
          end
        end else if (over_p || over_n) begin
          state_next = (steps == SW'(MAX_STEPS)) ? ST_DONE : ST_STEP;
        end else if (idx == NIDX_BITS'(NEIGHBOURS - 1)) begin
          state_next = ST_DONE;
        end else begin
          state_next = ST_DOT;
        end
      end
      ST_STEP: state_next = ST_DOT;
      ST_DONE: if (!obusy) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // The sequencer: ST_DOT registers a dot product; ST_CMP decides.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      obusy <= 1'b0;
    end else begin
      state <= state_next;
      if (out_ch.valid && out_ch.ready) obusy <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (q_valid) begin
            v[0] <= VW'(q_data.x);
            v[1] <= VW'(q_data.y);
            v[2] <= VW'(q_data.z);
            idx <= '0;
            in_cell <= 1'b1;
            running <= 1'b0;
            stepping <= 1'b0;
            changed <= 1'b0;
            capped <= 1'b0;
            pass <= '0;
            steps <= '0;
          end
        end
        ST_DOT: begin
          dot <= dn;
        end
        ST_CMP: begin
          if (!running) begin
            // Initial inside test over all neighbours.
            if (over_p || over_n) in_cell <= 1'b0;
            if (idx == NIDX_BITS'(NEIGHBOURS - 1)) begin
              idx <= '0;
              running <= 1'b1;
            end else begin
              idx <= idx + 1'b1;
            end
          end else if (stepping) begin
            // Continue the run on the same neighbour while the bound fails.
            if (pos ? over_p : over_n) begin
              if (steps == SW'(MAX_STEPS)) capped <= 1'b1;
            end else begin
              // Pass ends after a run.
              stepping <= 1'b0;
              idx <= '0;
              pass <= pass + 1'b1;
            end
          end else if (over_p || over_n) begin
            pos <= over_p;
            changed <= 1'b1;
            stepping <= 1'b1;
            if (steps == SW'(MAX_STEPS)) capped <= 1'b1;
          end else if (idx == NIDX_BITS'(NEIGHBOURS - 1)) begin
            changed <= 1'b0;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        ST_STEP: begin
          for (int k = 0; k < 3; k++) begin
            v[k] <= pos ? v[k] - VW'(nb[idx][k]) : v[k] + VW'(nb[idx][k]);
          end
          steps <= steps + 1'b1;
        end
        ST_DONE: begin
          if (!obusy) begin
            out_ch.folded_x <= sat(v[0]);
            out_ch.folded_y <= sat(v[1]);
            out_ch.folded_z <= sat(v[2]);
            out_ch.was_inside <= in_cell;
            out_ch.converged <= !changed && !capped && !ov(v[0]) && !ov(v[1]) && !ov(v[2]);
            obusy <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  assign out_ch.valid = obusy;
endmodule

// ===== rtl/core/wigner_seitz_fold.sv =====
// Top level of the Wigner-Seitz fold block: APB registers, front queue, back end.
// Depends on wsf_pkg, wsf_if, wsf_front and wsf_back.
//
// Each item folds one Q21.10 position into the Wigner-Seitz cell of the lattice
// held in three 63-bit registers (at byte addresses 0, 8 and 16). The back end
// forms each dot product in ST_DOT and compares it in ST_CMP: first the inside
// test over all thirteen neighbours, then passes over the neighbours, each
// broken bound followed by translation steps in ST_STEP, over at most
// MAX_PASSES passes and MAX_STEPS steps, and then the output. A two-entry queue
// in front lets new items be taken while one is folded, and the result register
// holds a finished item until it is taken. Registers must be written while
// idle; the derived norms are registered and settle in the cycle after a write.
module wigner_seitz_fold import wsf_pkg::*; #(
  parameter int MAX_PASSES = MAX_PASSES_DEF,
  parameter int MAX_STEPS = MAX_STEPS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  wsf_in_if.sink      in_ch,
  wsf_out_if.source   out_ch
);
  logic [62:0] lat_a, lat_b, lat_c;
  logic        q_valid, q_pop;
  pos_t        q_data;
  logic        wr;

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;

  // Register index is the address divided by eight.
  always_ff @(posedge clk) begin
    if (rst) begin
      lat_a <= '0;
      lat_b <= '0;
      lat_c <= '0;
    end else if (wr) begin
      case (paddr[4:3])
        REG_A:   lat_a <= pwdata[62:0];
        REG_B:   lat_b <= pwdata[62:0];
        REG_C:   lat_c <= pwdata[62:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:3])
      REG_A:   prdata = {1'b0, lat_a};
      REG_B:   prdata = {1'b0, lat_b};
      REG_C:   prdata = {1'b0, lat_c};
      default: prdata = '0;
    endcase
  end

  wsf_front u_front (
    .clk(clk), .rst(rst), .in_ch(in_ch),
    .q_valid(q_valid), .q_data(q_data), .q_pop(q_pop)
  );

  wsf_back #(.MAX_PASSES(MAX_PASSES), .MAX_STEPS(MAX_STEPS)) u_back (
    .clk(clk), .rst(rst), .lat_a(lat_a), .lat_b(lat_b), .lat_c(lat_c),
    .q_valid(q_valid), .q_data(q_data), .q_pop(q_pop), .out_ch(out_ch)
  );

  // A queue pop only happens when the queue holds an item.
  a_pop_valid: assert property (@(posedge clk) disable iff (rst) q_pop |-> q_valid)
    else $error("pop from empty queue");
  // A held result stays until taken.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.ready |=> out_ch.valid)
    else $error("result dropped");
endmodule

// ===== bench/wigner_seitz_fold_tb.sv =====
// Self-checking testbench for wigner_seitz_fold: folds positions into the
// Wigner-Seitz cell of several lattices and checks every result against a
// built-in predictor. Depends on wsf_pkg, wsf_if and the RTL of the block.
module wigner_seitz_fold_tb;
  import wsf_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // Limit of cycles in which neither channel moves an item and no register access runs.
  localparam int WATCHDOG_LIMIT = 40000;
  // Idle cycles after the final drain before the verdict is given.
  localparam int DRAIN_CYCLES = 64;
  // Byte address beyond the three lattice registers; writes there are ignored.
  localparam logic [4:0] UNUSED_ADDR = 5'd24;
  localparam int LAT_MAX = (1 << (LAT_BITS - 1)) - 1;
  localparam int LAT_MIN = -(1 << (LAT_BITS - 1));

  typedef struct {
    logic signed [POS_BITS-1:0] x;
    logic signed [POS_BITS-1:0] y;
    logic signed [POS_BITS-1:0] z;
    logic in_cell;
    logic conv;
  } fold_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic pready;

  wsf_in_if in_ch ();
  wsf_out_if out_ch ();

  wigner_seitz_fold dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_ch(in_ch), .out_ch(out_ch)
  );

  always #4 clk = ~clk;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.vec_x = '0;
    in_ch.vec_y = '0;
    in_ch.vec_z = '0;
    out_ch.ready = 1'b0;
  end

  // Predictor state: the lattice registers and the translations and squared
  // norms derived from them, kept exactly as wide integers.
  logic [62:0] lattice_reg [3];
  longint nb_comp [NEIGHBOURS][3];
  longint nb_norm [NEIGHBOURS];
  // Coefficients of a, b and c for each neighbour translation.
  int nb_coef [NEIGHBOURS][3] = '{
    '{1, 0, 0}, '{0, 1, 0}, '{0, 0, 1}, '{1, 1, 0}, '{1, -1, 0},
    '{0, 1, 1}, '{0, 1, -1}, '{1, 0, 1}, '{-1, 0, 1}, '{1, 1, 1},
    '{1, -1, -1}, '{1, 1, -1}, '{1, -1, 1}
  };

  fold_result_t pending_folds [$];
  int failures = 0;
  bit tx_jitter = 1'b1;
  bit rx_jitter = 1'b1;
  int hold_request = 0;
  int lat_scale = 1024;

  function automatic void rebuild_neighbours();
    longint lat [3][3];
    logic signed [LAT_BITS-1:0] comp;
    longint s;
    for (int r = 0; r < 3; r++)
      for (int k = 0; k < 3; k++) begin
        comp = lattice_reg[r][LAT_BITS*k +: LAT_BITS];
        lat[r][k] = comp;
      end
    for (int n = 0; n < NEIGHBOURS; n++) begin
      nb_norm[n] = 0;
      for (int k = 0; k < 3; k++) begin
        s = 0;
        for (int j = 0; j < 3; j++) s += nb_coef[n][j] * lat[j][k];
        nb_comp[n][k] = s;
        nb_norm[n] += s * s;
      end
    end
  endfunction

  function automatic longint dot_neighbour(input longint v [3], input int n);
    return v[0] * nb_comp[n][0] + v[1] * nb_comp[n][1] + v[2] * nb_comp[n][2];
  endfunction

  function automatic logic signed [POS_BITS-1:0] clamp_pos(input longint x,
                                                           inout bit ovf);
    if (x > 64'sd2147483647) begin
      ovf = 1'b1;
      return 32'sh7fffffff;
    end
    if (x < -64'sd2147483648) begin
      ovf = 1'b1;
      return 32'sh80000000;
    end
    return x[POS_BITS-1:0];
  endfunction

  // Folds one position the way the block must: the inside test against all
  // thirteen neighbours first, then passes that stop at the first neighbour
  // whose bound is broken and step along it until the bound holds again.
  function automatic fold_result_t fold_position(input logic signed [31:0] px,
                                                 input logic signed [31:0] py,
                                                 input logic signed [31:0] pz);
    longint v [3];
    longint d;
    longint sgn;
    bit in_cell, done, capped, ovf, again;
    int steps;
    fold_result_t r;
    v[0] = px;
    v[1] = py;
    v[2] = pz;
    in_cell = 1'b1;
    for (int n = 0; n < NEIGHBOURS; n++) begin
      d = dot_neighbour(v, n);
      if (d < 0) d = -d;
      if (2 * d > nb_norm[n]) in_cell = 1'b0;
    end
    done = 1'b0;
    capped = 1'b0;
    ovf = 1'b0;
    steps = 0;
    for (int pass = 0; pass < MAX_PASSES_DEF && !done && !capped; pass++) begin
      done = 1'b1;
      for (int n = 0; n < NEIGHBOURS && done && !capped; n++) begin
        d = dot_neighbour(v, n);
        if (2 * d > nb_norm[n]) sgn = -1;
        else if (-2 * d > nb_norm[n]) sgn = 1;
        else continue;
        done = 1'b0;
        again = 1'b1;
        while (again) begin
          if (steps >= MAX_STEPS_DEF) begin
            capped = 1'b1;
            again = 1'b0;
          end else begin
            for (int k = 0; k < 3; k++) v[k] += sgn * nb_comp[n][k];
            steps++;
            d = dot_neighbour(v, n);
            again = (sgn < 0) ? (2 * d > nb_norm[n]) : (-2 * d > nb_norm[n]);
          end
        end
      end
    end
    r.x = clamp_pos(v[0], ovf);
    r.y = clamp_pos(v[1], ovf);
    r.z = clamp_pos(v[2], ovf);
    r.in_cell = in_cell;
    r.conv = done && !capped && !ovf;
    return r;
  endfunction

  // Receiver: random stalls per item, plus a long hold-off on request. Each
  // result is compared with the oldest expectation as it is taken.
  int rx_wait = 0;
  int hold_left = 0;
  always @(posedge clk) begin
    fold_result_t exp_r;
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (hold_request != 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (out_ch.valid && out_ch.ready) begin
        if (pending_folds.size() == 0) begin
          failures++;
          $display("%0t: unexpected result x=%0d y=%0d z=%0d", $time,
                   out_ch.folded_x, out_ch.folded_y, out_ch.folded_z);
        end else begin
          exp_r = pending_folds.pop_front();
          if (out_ch.folded_x !== exp_r.x) begin
            failures++;
            $display("%0t: folded_x expected %0d actual %0d", $time, exp_r.x,
                     out_ch.folded_x);
          end
          if (out_ch.folded_y !== exp_r.y) begin
            failures++;
            $display("%0t: folded_y expected %0d actual %0d", $time, exp_r.y,
                     out_ch.folded_y);
          end
          if (out_ch.folded_z !== exp_r.z) begin
            failures++;
            $display("%0t: folded_z expected %0d actual %0d", $time, exp_r.z,
                     out_ch.folded_z);
          end
          if (out_ch.was_inside !== exp_r.in_cell) begin
            failures++;
            $display("%0t: was_inside expected %0b actual %0b", $time,
                     exp_r.in_cell, out_ch.was_inside);
          end
          if (out_ch.converged !== exp_r.conv) begin
            failures++;
            $display("%0t: converged expected %0b actual %0b", $time,
                     exp_r.conv, out_ch.converged);
          end
        end
        rx_wait = rx_jitter ? $urandom_range(0, 6) : 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (rx_wait > 0) begin
        rx_wait--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog: ends the run when neither channel nor the register bus has moved for too long.
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || psel)
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: timeout, %0d results outstanding", $time,
               pending_folds.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Offers one position after a random gap; the valid stays high after the
  // handshake so that back-to-back items follow with no gap.
  task automatic send_position(input logic signed [31:0] px,
                               input logic signed [31:0] py,
                               input logic signed [31:0] pz);
    int gap;
    gap = tx_jitter ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.vec_x <= px;
    in_ch.vec_y <= py;
    in_ch.vec_z <= pz;
    do @(posedge clk); while (!in_ch.ready);
    pending_folds.push_back(fold_position(px, py, pz));
  endtask

  // Lowers the valid and waits until every result is back, then lets the
  // block settle before the lattice may change.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (pending_folds.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_register(input logic [4:0] addr, input logic [63:0] data);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    // Bit 63 has no storage; unused addresses change nothing.
    if (addr == {REG_A, 3'b000}) lattice_reg[0] = data[62:0];
    else if (addr == {REG_B, 3'b000}) lattice_reg[1] = data[62:0];
    else if (addr == {REG_C, 3'b000}) lattice_reg[2] = data[62:0];
    rebuild_neighbours();
    repeat (2) @(posedge clk);
  endtask

  function automatic logic [63:0] pack_vector(input int x, input int y, input int z);
    logic [20:0] cx, cy, cz;
    cx = x[20:0];
    cy = y[20:0];
    cz = z[20:0];
    // The spare top bit is set at random to show that it is dropped.
    return {1'($urandom_range(0, 1)), cz, cy, cx};
  endfunction

  task automatic load_lattice(input int ax, input int ay, input int az,
                              input int bx, input int by, input int bz,
                              input int cx, input int cy, input int cz);
    write_register({REG_A, 3'b000}, pack_vector(ax, ay, az));
    write_register({REG_B, 3'b000}, pack_vector(bx, by, bz));
    write_register({REG_C, 3'b000}, pack_vector(cx, cy, cz));
  endtask

  function automatic int rand_component(input int span);
    return $urandom_range(0, 2 * span) - span;
  endfunction

  // Mostly positions a few cells from the origin, so that folds take several
  // steps and passes; some are full-range words and some sit at the edges.
  task automatic send_random_position();
    int mode;
    int span;
    logic signed [31:0] p [3];
    mode = $urandom_range(0, 9);
    span = lat_scale * 6;
    if (span > (1 << 30)) span = 1 << 30;
    for (int k = 0; k < 3; k++) begin
      case (mode)
        0: p[k] = $urandom;
        1: p[k] = $urandom_range(0, 1) ? 32'sh7fffffff - $urandom_range(0, 255)
                                       : 32'sh80000000 + $urandom_range(0, 255);
        default: p[k] = rand_component(span);
      endcase
    end
    send_position(p[0], p[1], p[2]);
  endtask

  task automatic run_random(input int count);
    for (int i = 0; i < count; i++) begin
      // Now and then a stretch with no gaps on one side or both.
      if (i % 40 == 0) begin
        tx_jitter = $urandom_range(0, 3) != 0;
        rx_jitter = $urandom_range(0, 3) != 0;
      end
      send_random_position();
    end
    tx_jitter = 1'b1;
    rx_jitter = 1'b1;
  endtask

  // With the lattice all zero after reset, every position is already inside
  // and comes back unchanged.
  task automatic test_zero_lattice();
    send_position(0, 0, 0);
    send_position(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff);
    send_position(32'sh80000000, 32'sh7fffffff, -1);
    drain_results();
  endtask

  // A cubic lattice of unit length: the half-way point is the boundary,
  // one step past it folds, and the word extremes run into the step cap.
  task automatic test_cubic_boundaries();
    lat_scale = 1024;
    load_lattice(1024, 0, 0, 0, 1024, 0, 0, 0, 1024);
    send_position(0, 0, 0);
    send_position(512, 0, 0);
    send_position(513, 0, 0);
    send_position(-513, 0, 0);
    send_position(512, 512, 512);
    send_position(2047, -2047, 1536);
    send_position(1024 * 7 + 3, -1024 * 5, 1024 * 3 + 600);
    send_position(32'sh7fffffff, 0, 0);
    send_position(32'sh80000000, 32'sh80000000, 32'sh80000000);
    send_position(-1, -1, -1);
    drain_results();
  endtask

  // A write to an address beyond the three registers must change nothing.
  task automatic test_unused_address();
    write_register(UNUSED_ADDR, 64'hffff_ffff_ffff_ffff);
    send_position(1500, -700, 2600);
    send_position(-3000, 3000, 10);
    drain_results();
  endtask

  // A degenerate lattice (a equal to b, so a-b is zero) and one at the
  // component extremes, where positions may be pushed past the word range.
  task automatic test_degenerate_and_extreme();
    lat_scale = 2048;
    load_lattice(2048, 0, 0, 2048, 0, 0, 0, 0, 2048);
    send_position(5000, 100, -7000);
    send_position(-3000, 9000, 1000);
    drain_results();
    lat_scale = 1 << 20;
    load_lattice(LAT_MAX, LAT_MAX, LAT_MAX, LAT_MIN, LAT_MAX, LAT_MIN,
                 LAT_MIN, LAT_MIN, LAT_MAX);
    send_position(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
    send_position(32'sh80000000, 32'sh7fffffff, 32'sh80000000);
    send_position(32'sh7fffff00, 32'sh80000000, 0);
    drain_results();
  endtask

  // The receiver holds off for a long stretch while items keep coming, so
  // that the front queue fills and the input stalls.
  task automatic test_backpressure();
    lat_scale = 1024;
    load_lattice(0, 1024, 1024, 1024, 0, 1024, 1024, 1024, 0);
    tx_jitter = 1'b0;
    hold_request = 400;
    for (int i = 0; i < 12; i++) send_random_position();
    tx_jitter = 1'b1;
    drain_results();
  endtask

  // A range of lattices, each loaded while idle and then fed random items.
  task automatic test_random_lattices();
    int s;
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: s = 1024;
        1: s = 300;
        2: s = 1 << 20;
        3: s = 64;
        default: s = $urandom_range(16, 1 << 19);
      endcase
      lat_scale = s;
      if (phase == 0)
        load_lattice(s, 0, 0, s / 2, (s * 7) / 8, 0, 0, 0, (s * 3) / 2);
      else
        load_lattice(rand_component(s), rand_component(s), rand_component(s),
                     rand_component(s), rand_component(s), rand_component(s),
                     rand_component(s), rand_component(s), rand_component(s));
      run_random(165);
      // The sender pauses here until every result has come.
      drain_results();
    end
  endtask

  initial begin
    for (int r = 0; r < 3; r++) lattice_reg[r] = '0;
    rebuild_neighbours();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_zero_lattice();
    test_cubic_boundaries();
    test_unused_address();
    test_degenerate_and_extreme();
    test_backpressure();
    test_random_lattices();
    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_folds.size() != 0) begin
      failures++;
      $display("%0t: %0d expected results never arrived", $time,
               pending_folds.size());
    end
    if (failures == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
rtl/core/wsf_pkg.sv
rtl/core/wsf_if.sv
rtl/core/wsf_front.sv
rtl/core/wsf_back.sv
rtl/core/wigner_seitz_fold.sv
bench/wigner_seitz_fold_tb.sv
